[rtl/pleo_pkg.sv]
// ----------------------------------------------------------------------------
// pleo_pkg
// Shared widths, types and constants of the polyline edge offset block.
// ----------------------------------------------------------------------------
package pleo_pkg;

  localparam int CoordBits  = 32;
  localparam int SatBits    = (CoordBits < 32) ? CoordBits : 32;
  localparam int XyBits     = 32;
  localparam int HwBits     = 24;
  localparam int CfgIdxBits = 2;

  localparam int QDepth     = 4;
  localparam int QPtrBits   = $clog2(QDepth);
  localparam int QCntBits   = $clog2(QDepth + 1);

  localparam int MagBits    = XyBits;
  localparam int SqBits     = 2 * MagBits;
  localparam int NumBits    = HwBits + MagBits;
  localparam int SqrtSteps  = MagBits;
  localparam int DivSteps   = HwBits;
  localparam int StepBits   = $clog2(SqrtSteps);
  localparam int OffBits    = XyBits + 2;

  localparam logic signed [OffBits-1:0] SatHi =
    OffBits'((longint'(1) <<< (SatBits - 1)) - 1);
  localparam logic signed [OffBits-1:0] SatLo = ~SatHi;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_HALF_WIDTH = 2'd0,
    REG_SIDE_RIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_TWO
  } seen_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_MULA,
    ST_MULB,
    ST_MULC,
    ST_DIV,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic signed [XyBits-1:0] px;
    logic signed [XyBits-1:0] py;
    logic signed [XyBits:0]   tx;
    logic signed [XyBits:0]   ty;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic room2;
    logic avail;
  } q_status_t;

endpackage

[rtl/polyline_edge_offset_top.sv]
// ----------------------------------------------------------------------------
// polyline_edge_offset_top: a point is accepted while the queue has room for two jobs.
// In the back end each result goes through the 32-step square root and the 24-step
// divide pair; a zero tangent skips them and goes straight to the output. Up to 4 jobs queue.
// Reset clears config, polyline position, queue and output; no clearing pass.
// ----------------------------------------------------------------------------
module polyline_edge_offset_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pleo_pkg::XyBits-1:0]   center_x_i,
  input  logic signed [pleo_pkg::XyBits-1:0]   center_y_i,
  input  logic                                 last_point_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pleo_pkg::XyBits-1:0]   edge_x_o,
  output logic signed [pleo_pkg::XyBits-1:0]   edge_y_o,
  output logic                                 edge_last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pleo_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [pleo_pkg::HwBits-1:0]          cfg_data_i
);
  import pleo_pkg::*;

  logic [HwBits-1:0] half_width_q;
  logic              side_right_q;
  logic [1:0]        push_n;
  job_t              job0, job1, head;
  q_status_t         q_status;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= '0;
      side_right_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HALF_WIDTH: half_width_q <= cfg_data_i;
        REG_SIDE_RIGHT: side_right_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  pleo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .last_point_i (last_point_i),
    .q_status_i   (q_status),
    .push_n_o     (push_n),
    .job0_o       (job0),
    .job1_o       (job1)
  );

  pleo_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .job0_i   (job0),
    .job1_i   (job1),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  pleo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .half_width_i (half_width_q),
    .side_right_i (side_right_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_x_o     (edge_x_o),
    .edge_y_o     (edge_y_o),
    .edge_last_o  (edge_last_o)
  );

endmodule

[rtl/pleo_front.sv]
// ----------------------------------------------------------------------------
// pleo_front
// Accepts centerline points, tracks the polyline position and issues offset
// jobs (point plus tangent) into the job queue.
// ----------------------------------------------------------------------------
module pleo_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [pleo_pkg::XyBits-1:0] center_x_i,
  input  logic signed [pleo_pkg::XyBits-1:0] center_y_i,
  input  logic                             last_point_i,
  input  pleo_pkg::q_status_t              q_status_i,
  output logic [1:0]                       push_n_o,
  output pleo_pkg::job_t                   job0_o,
  output pleo_pkg::job_t                   job1_o
);
  import pleo_pkg::*;

  seen_e                    seen_q, seen_d;
  logic signed [XyBits-1:0] older_x_q, older_y_q, held_x_q, held_y_q;
  logic signed [XyBits:0]   cx, cy, hx, hy, ox, oy;
  logic                     take;

  assign take       = in_valid_i && q_status_i.room2;
  assign in_stall_o = !q_status_i.room2;

  assign cx = (XyBits+1)'(center_x_i);
  assign cy = (XyBits+1)'(center_y_i);
  assign hx = (XyBits+1)'(held_x_q);
  assign hy = (XyBits+1)'(held_y_q);
  assign ox = (XyBits+1)'(older_x_q);
  assign oy = (XyBits+1)'(older_y_q);

  always_comb begin
    seen_d      = seen_q;
    push_n_o    = 2'd0;
    job0_o.px   = held_x_q;
    job0_o.py   = held_y_q;
    job0_o.tx   = cx - ox;
    job0_o.ty   = cy - oy;
    job0_o.last = 1'b0;
    job1_o.px   = center_x_i;
    job1_o.py   = center_y_i;
    job1_o.tx   = cx - hx;
    job1_o.ty   = cy - hy;
    job1_o.last = 1'b1;
    if (seen_q == SEEN_ONE) begin
      job0_o.tx = cx - hx;
      job0_o.ty = cy - hy;
    end
    if (take) begin
      unique case (seen_q)
        SEEN_NONE: begin
          seen_d = last_point_i ? SEEN_NONE : SEEN_ONE;
        end
        default: begin
          push_n_o = last_point_i ? 2'd2 : 2'd1;
          seen_d   = last_point_i ? SEEN_NONE : SEEN_TWO;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SEEN_NONE;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      older_x_q <= held_x_q;
      older_y_q <= held_y_q;
      held_x_q  <= center_x_i;
      held_y_q  <= center_y_i;
    end
  end

endmodule

[rtl/pleo_queue.sv]
// ----------------------------------------------------------------------------
// pleo_queue
// Short job queue between front and back; takes up to two jobs per cycle.
// ----------------------------------------------------------------------------
module pleo_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  pleo_pkg::job_t      job0_i,
  input  pleo_pkg::job_t      job1_i,
  input  logic                pop_i,
  output pleo_pkg::job_t      head_o,
  output pleo_pkg::q_status_t status_o
);
  import pleo_pkg::*;

  job_t                mem_q [QDepth];
  logic [QPtrBits-1:0] wr_ptr_q, rd_ptr_q, wr_next;
  logic [QCntBits-1:0] count_q;
  logic                do_pop;

  assign do_pop         = pop_i && (count_q != '0);
  assign wr_next        = wr_ptr_q + 1'b1;
  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.avail = (count_q != '0);
  assign status_o.room2 = (count_q <= QCntBits'(QDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= job0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_next] <= job1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrBits'(push_n_i);
      rd_ptr_q <= rd_ptr_q + QPtrBits'(do_pop);
      count_q  <= count_q + QCntBits'(push_n_i) - QCntBits'(do_pop);
    end
  end

endmodule

[rtl/pleo_back.sv]
// ----------------------------------------------------------------------------
// pleo_back
// Executes one offset job at a time: normalize, sum of squares, iterative
// square root, two parallel restoring divides, offset add and saturate.
// ----------------------------------------------------------------------------
module pleo_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pleo_pkg::job_t                     head_i,
  input  pleo_pkg::q_status_t                q_status_i,
  output logic                               pop_o,
  input  logic [pleo_pkg::HwBits-1:0]        half_width_i,
  input  logic                               side_right_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pleo_pkg::XyBits-1:0] edge_x_o,
  output logic signed [pleo_pkg::XyBits-1:0] edge_y_o,
  output logic                               edge_last_o
);
  import pleo_pkg::*;

  back_state_e              state_q, state_d;
  logic signed [XyBits-1:0] px_q, py_q;
  logic                     ty_neg_q, tx_pos_q, last_q;
  logic [MagBits-1:0]       ax_q, ay_q, m;
  logic [SqBits-1:0]        p_q, acc_q, res_q, bit_q, trial;
  logic [StepBits-1:0]      cnt_q;
  logic [MagBits-1:0]       rx_q, ry_q, len, half_len;
  logic [DivSteps-1:0]      qx_q, qy_q;
  logic [MagBits-1:0]       mul_a, mul_b;
  logic [SqBits-1:0]        product;
  logic [NumBits-1:0]       num;
  logic [MagBits:0]         rx2, ry2;
  logic                     gx, gy, sq_ge;
  logic [MagBits-1:0]       in_ax, in_ay;
  logic                     in_zero, out_free, load_out;
  logic                     negx, negy;
  logic signed [OffBits-1:0] offx, offy, ex, ey;
  logic signed [XyBits-1:0] edge_x_q, edge_y_q;
  logic                     edge_last_q, out_valid_q;

  function automatic logic signed [XyBits-1:0] sat_xy(input logic signed [OffBits-1:0] v);
    logic signed [XyBits-1:0] r;
    if (v > SatHi) begin
      r = XyBits'(SatHi);
    end else if (v < SatLo) begin
      r = XyBits'(SatLo);
    end else begin
      r = XyBits'(v);
    end
    return r;
  endfunction

  assign in_ax   = head_i.tx[XyBits] ? MagBits'(-head_i.tx) : MagBits'(head_i.tx);
  assign in_ay   = head_i.ty[XyBits] ? MagBits'(-head_i.ty) : MagBits'(head_i.ty);
  assign in_zero = (in_ax == '0) && (in_ay == '0);

  assign m        = (ax_q > ay_q) ? ax_q : ay_q;
  assign len      = res_q[MagBits-1:0];
  assign half_len = len >> 1;
  assign trial    = res_q + bit_q;
  assign sq_ge    = (acc_q >= trial);
  assign num      = p_q[NumBits-1:0] + NumBits'(half_len);
  assign rx2      = {rx_q, qx_q[DivSteps-1]};
  assign ry2      = {ry_q, qy_q[DivSteps-1]};
  assign gx       = (rx2 >= {1'b0, len});
  assign gy       = (ry2 >= {1'b0, len});

  always_comb begin
    mul_a = ax_q;
    mul_b = ax_q;
    unique case (state_q)
      ST_SQY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      ST_MULA: begin
        mul_a = MagBits'(half_width_i);
        mul_b = ay_q;
      end
      ST_MULB: begin
        mul_a = MagBits'(half_width_i);
        mul_b = ax_q;
      end
      default: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
    endcase
  end

  assign product = SqBits'(mul_a) * SqBits'(mul_b);

  assign negx = !(ty_neg_q ^ side_right_i);
  assign negy = !(tx_pos_q ^ side_right_i);
  assign offx = $signed({{(OffBits-DivSteps){1'b0}}, qx_q});
  assign offy = $signed({{(OffBits-DivSteps){1'b0}}, qy_q});
  assign ex   = OffBits'(px_q) + (negx ? -offx : offx);
  assign ey   = OffBits'(py_q) + (negy ? -offy : offy);

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_status_i.avail) begin
          pop_o   = 1'b1;
          state_d = in_zero ? ST_FIN : ST_NORM;
        end
      end
      ST_NORM: begin
        if (m[MagBits-1] || m[MagBits-2]) begin
          state_d = ST_SQX;
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == StepBits'(SqrtSteps - 1)) begin
          state_d = ST_MULA;
        end
      end
      ST_MULA: state_d = ST_MULB;
      ST_MULB: state_d = ST_MULC;
      ST_MULC: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == StepBits'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        px_q     <= head_i.px;
        py_q     <= head_i.py;
        ty_neg_q <= head_i.ty[XyBits];
        tx_pos_q <= !head_i.tx[XyBits] && (head_i.tx != '0);
        last_q   <= head_i.last;
        ax_q     <= in_ax;
        ay_q     <= in_ay;
        qx_q     <= '0;
        qy_q     <= '0;
      end
      ST_NORM: begin
        if (m[MagBits-1]) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end else if (m[MagBits-1:MagBits-10] == '0) begin
          ax_q <= ax_q << 8;
          ay_q <= ay_q << 8;
        end else if (!m[MagBits-2]) begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end
      end
      ST_SQX: begin
        p_q <= product;
      end
      ST_SQY: begin
        acc_q <= p_q;
        p_q   <= product;
      end
      ST_SUM: begin
        acc_q <= acc_q + p_q;
        res_q <= '0;
        bit_q <= SqBits'(1) << (SqBits - 2);
        cnt_q <= '0;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          acc_q <= acc_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_MULA: begin
        p_q <= product;
      end
      ST_MULB: begin
        rx_q <= num[NumBits-1:DivSteps];
        qx_q <= num[DivSteps-1:0];
        p_q  <= product;
      end
      ST_MULC: begin
        ry_q  <= num[NumBits-1:DivSteps];
        qy_q  <= num[DivSteps-1:0];
        cnt_q <= '0;
      end
      ST_DIV: begin
        rx_q  <= gx ? MagBits'(rx2 - {1'b0, len}) : rx2[MagBits-1:0];
        ry_q  <= gy ? MagBits'(ry2 - {1'b0, len}) : ry2[MagBits-1:0];
        qx_q  <= {qx_q[DivSteps-2:0], gx};
        qy_q  <= {qy_q[DivSteps-2:0], gy};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      edge_x_q    <= sat_xy(ex);
      edge_y_q    <= sat_xy(ey);
      edge_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign edge_x_o    = edge_x_q;
  assign edge_y_o    = edge_y_q;
  assign edge_last_o = edge_last_q;

endmodule

[rtl/pleo_checker.sv]
// ----------------------------------------------------------------------------
// pleo_checker
// Port-level checks on the polyline edge offset block, bound to the top level.
// ----------------------------------------------------------------------------
module pleo_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic signed [pleo_pkg::XyBits-1:0] center_x_i,
  input logic signed [pleo_pkg::XyBits-1:0] center_y_i,
  input logic                               last_point_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [pleo_pkg::XyBits-1:0] edge_x_o,
  input logic signed [pleo_pkg::XyBits-1:0] edge_y_o,
  input logic                               edge_last_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [pleo_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input logic [pleo_pkg::HwBits-1:0]        cfg_data_i
);
  import pleo_pkg::*;

  seen_e      seen_q;
  logic [3:0] owed_q, owed_add;
  logic       in_take, out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  always_comb begin
    owed_add = 4'd0;
    if (in_take && (seen_q != SEEN_NONE)) begin
      owed_add = last_point_i ? 4'd2 : 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SEEN_NONE;
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + owed_add - 4'(out_take);
      if (in_take) begin
        if (last_point_i) begin
          seen_q <= SEEN_NONE;
        end else if (seen_q == SEEN_NONE) begin
          seen_q <= SEEN_ONE;
        end else begin
          seen_q <= SEEN_TWO;
        end
      end
    end
  end

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(edge_x_o) && $stable(edge_y_o)
      && $stable(edge_last_o))
    else $error("stalled result payload changed");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> owed_q != 4'd0)
    else $error("result transaction without an owed point");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config transaction refused");

endmodule

bind polyline_edge_offset_top pleo_checker u_pleo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .center_x_i   (center_x_i),
  .center_y_i   (center_y_i),
  .last_point_i (last_point_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .edge_x_o     (edge_x_o),
  .edge_y_o     (edge_y_o),
  .edge_last_o  (edge_last_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .cfg_index_i  (cfg_index_i),
  .cfg_data_i   (cfg_data_i)
);
